// ===== rtl/core/cau_pkg.sv =====
// shared types and operation codes for the complex arithmetic unit
// no dependencies; imported by every module of the unit
package cau_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_SUB = 2'd1;
  localparam cmd_t CMD_MUL = 2'd2;
  localparam cmd_t CMD_DIV = 2'd3;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic vld;
    cmd_t cmd;
    logic dz;
  } ctl_t;

endpackage

// ===== rtl/core/cau_front.sv =====
// front end of the complex arithmetic unit: products, sums, add/sub/mul results
// and divider setup (sign/magnitude numerators, overflow precheck), four stages
// depends on cau_pkg
module cau_front import cau_pkg::*; #(
  parameter int DW = 16,
  parameter int FB = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  cmd_t                    in_cmd,
  input  logic signed [DW-1:0]    a_re,
  input  logic signed [DW-1:0]    a_im,
  input  logic signed [DW-1:0]    b_re,
  input  logic signed [DW-1:0]    b_im,
  output ctl_t                    ctl_o,
  output logic [2*DW-1:0]         den_o,
  output logic [DW-1:0]           pass_re_o,
  output logic [DW-1:0]           pass_im_o,
  output logic                    pass_sat_o,
  output logic [2*DW-1:0]         rem_re_o,
  output logic [2*DW-1:0]         rem_im_o,
  output logic [DW:0]             xlo_re_o,
  output logic [DW:0]             xlo_im_o,
  output logic                    neg_re_o,
  output logic                    neg_im_o,
  output logic                    ovf_re_o,
  output logic                    ovf_im_o
);

  localparam int PW = 2 * DW;       // product width
  localparam int RW = 2 * DW;       // divisor / remainder width
  localparam int AW = DW + 1;       // add/sub width
  localparam int SW = 2 * DW + 1;   // sum of products width
  localparam int QW = DW + 1;       // quotient bits
  localparam int XW = 2 * DW + FB;  // scaled numerator width

  localparam logic signed [SW-1:0] VMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // returns {sat, value}
  function automatic logic [DW:0] clip_f(input logic signed [SW-1:0] v);
    logic [DW:0] res;
    if (v > VMAX) begin
      res = {1'b1, VMAX[DW-1:0]};
    end else if (v < VMIN) begin
      res = {1'b1, VMIN[DW-1:0]};
    end else begin
      res = {1'b0, v[DW-1:0]};
    end
    return res;
  endfunction

  // stage 1: multipliers and add/sub
  ctl_t                 ctl1_r, ctl1_nxt;
  logic signed [PW-1:0] prr1_r, pii1_r, pri1_r, pir1_r;
  logic [RW-1:0]        sqr1_r, sqi1_r;
  logic signed [AW-1:0] asr1_r, asi1_r;

  always_comb begin
    ctl1_nxt.vld = in_vld;
    ctl1_nxt.cmd = in_cmd;
    ctl1_nxt.dz  = (in_cmd == CMD_DIV) && (b_re == '0) && (b_im == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prr1_r <= PW'(a_re) * PW'(b_re);
    pii1_r <= PW'(a_im) * PW'(b_im);
    pri1_r <= PW'(a_re) * PW'(b_im);
    pir1_r <= PW'(a_im) * PW'(b_re);
    sqr1_r <= RW'(PW'(b_re) * PW'(b_re));
    sqi1_r <= RW'(PW'(b_im) * PW'(b_im));
    if (in_cmd == CMD_SUB) begin
      asr1_r <= AW'(a_re) - AW'(b_re);
      asi1_r <= AW'(a_im) - AW'(b_im);
    end else begin
      asr1_r <= AW'(a_re) + AW'(b_re);
      asi1_r <= AW'(a_im) + AW'(b_im);
    end
  end

  // stage 2: combine products, sum divisor squares, pass add/sub through
  ctl_t                 ctl2_r;
  logic signed [SW-1:0] sre2_r, sim2_r, sre2_nxt, sim2_nxt;
  logic [RW-1:0]        den2_r;

  always_comb begin
    unique case (ctl1_r.cmd)
      CMD_MUL: begin
        sre2_nxt = SW'(prr1_r) - SW'(pii1_r);
        sim2_nxt = SW'(pri1_r) + SW'(pir1_r);
      end
      CMD_DIV: begin
        sre2_nxt = SW'(prr1_r) + SW'(pii1_r);
        sim2_nxt = SW'(pir1_r) - SW'(pri1_r);
      end
      default: begin
        sre2_nxt = SW'(asr1_r);
        sim2_nxt = SW'(asi1_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    sre2_r <= sre2_nxt;
    sim2_r <= sim2_nxt;
    den2_r <= sqr1_r + sqi1_r;
  end

  // stage 3: clip add/sub/mul, sign/magnitude for divide
  ctl_t                 ctl3_r;
  logic [RW-1:0]        den3_r;
  logic [DW-1:0]        pre3_r, pim3_r;
  logic                 psat3_r;
  logic                 negr3_r, negi3_r;
  logic [XW-1:0]        xr3_r, xi3_r;
  logic signed [SW-1:0] cin_re, cin_im, mag_re, mag_im;
  logic [DW:0]          clp_re, clp_im;

  always_comb begin
    if (ctl2_r.cmd == CMD_MUL) begin
      cin_re = sre2_r >>> FB;
      cin_im = sim2_r >>> FB;
    end else begin
      cin_re = sre2_r;
      cin_im = sim2_r;
    end
    clp_re = clip_f(cin_re);
    clp_im = clip_f(cin_im);
    mag_re = sre2_r[SW-1] ? -sre2_r : sre2_r;
    mag_im = sim2_r[SW-1] ? -sim2_r : sim2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else begin
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    den3_r  <= den2_r;
    pre3_r  <= clp_re[DW-1:0];
    pim3_r  <= clp_im[DW-1:0];
    psat3_r <= clp_re[DW] | clp_im[DW];
    negr3_r <= sre2_r[SW-1];
    negi3_r <= sim2_r[SW-1];
    xr3_r   <= XW'(mag_re[RW-1:0]) << FB;
    xi3_r   <= XW'(mag_im[RW-1:0]) << FB;
  end

  // stage 4: quotient overflow check and initial remainder
  ctl_t          ctl4_r;
  logic [RW-1:0] den4_r;
  logic [DW-1:0] pre4_r, pim4_r;
  logic          psat4_r;
  logic          negr4_r, negi4_r, ovfr4_r, ovfi4_r;
  logic [RW-1:0] remr4_r, remi4_r;
  logic [QW-1:0] xlor4_r, xloi4_r;
  logic [XW-1:0] hir, hii;

  always_comb begin
    hir = xr3_r >> QW;
    hii = xi3_r >> QW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else begin
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    den4_r  <= den3_r;
    pre4_r  <= pre3_r;
    pim4_r  <= pim3_r;
    psat4_r <= psat3_r;
    negr4_r <= negr3_r;
    negi4_r <= negi3_r;
    // quotient would not fit in QW bits
    ovfr4_r <= hir >= XW'(den3_r);
    ovfi4_r <= hii >= XW'(den3_r);
    remr4_r <= hir[RW-1:0];
    remi4_r <= hii[RW-1:0];
    xlor4_r <= xr3_r[QW-1:0];
    xloi4_r <= xi3_r[QW-1:0];
  end

  assign ctl_o      = ctl4_r;
  assign den_o      = den4_r;
  assign pass_re_o  = pre4_r;
  assign pass_im_o  = pim4_r;
  assign pass_sat_o = psat4_r;
  assign rem_re_o   = remr4_r;
  assign rem_im_o   = remi4_r;
  assign xlo_re_o   = xlor4_r;
  assign xlo_im_o   = xloi4_r;
  assign neg_re_o   = negr4_r;
  assign neg_im_o   = negi4_r;
  assign ovf_re_o   = ovfr4_r;
  assign ovf_im_o   = ovfi4_r;

endmodule

// ===== rtl/core/cau_div_step.sv =====
// one restoring division step for both result lanes, one quotient bit per stage
// depends on cau_pkg
module cau_div_step import cau_pkg::*; #(
  parameter int DW  = 16,
  parameter int BIT = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_t            ctl_i,
  input  logic [2*DW-1:0] den_i,
  input  logic [DW-1:0]   pass_re_i,
  input  logic [DW-1:0]   pass_im_i,
  input  logic            pass_sat_i,
  input  logic [2*DW-1:0] rem_re_i,
  input  logic [2*DW-1:0] rem_im_i,
  input  logic [DW:0]     q_re_i,
  input  logic [DW:0]     q_im_i,
  input  logic [DW:0]     xlo_re_i,
  input  logic [DW:0]     xlo_im_i,
  input  logic            neg_re_i,
  input  logic            neg_im_i,
  input  logic            ovf_re_i,
  input  logic            ovf_im_i,
  output ctl_t            ctl_o,
  output logic [2*DW-1:0] den_o,
  output logic [DW-1:0]   pass_re_o,
  output logic [DW-1:0]   pass_im_o,
  output logic            pass_sat_o,
  output logic [2*DW-1:0] rem_re_o,
  output logic [2*DW-1:0] rem_im_o,
  output logic [DW:0]     q_re_o,
  output logic [DW:0]     q_im_o,
  output logic [DW:0]     xlo_re_o,
  output logic [DW:0]     xlo_im_o,
  output logic            neg_re_o,
  output logic            neg_im_o,
  output logic            ovf_re_o,
  output logic            ovf_im_o
);

  localparam int RW = 2 * DW;
  localparam int QW = DW + 1;

  // returns {quotient bit, next remainder}
  function automatic logic [RW:0] step_f(input logic [RW-1:0] r, input logic b,
                                         input logic [RW-1:0] d);
    logic [RW:0] rs;
    logic [RW:0] df;
    logic        ge;
    rs = {r, b};
    df = rs - {1'b0, d};
    ge = rs >= {1'b0, d};
    return ge ? {1'b1, df[RW-1:0]} : {1'b0, rs[RW-1:0]};
  endfunction

  ctl_t          ctl_r;
  logic [RW-1:0] den_r, remr_r, remi_r;
  logic [DW-1:0] pre_r, pim_r;
  logic          psat_r, negr_r, negi_r, ovfr_r, ovfi_r;
  logic [QW-1:0] qr_r, qi_r, xlor_r, xloi_r, qr_nxt, qi_nxt;
  logic [RW:0]   str, sti;

  always_comb begin
    str    = step_f(rem_re_i, xlo_re_i[BIT], den_i);
    sti    = step_f(rem_im_i, xlo_im_i[BIT], den_i);
    qr_nxt = q_re_i;
    qi_nxt = q_im_i;
    qr_nxt[BIT] = str[RW];
    qi_nxt[BIT] = sti[RW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    den_r  <= den_i;
    pre_r  <= pass_re_i;
    pim_r  <= pass_im_i;
    psat_r <= pass_sat_i;
    remr_r <= str[RW-1:0];
    remi_r <= sti[RW-1:0];
    qr_r   <= qr_nxt;
    qi_r   <= qi_nxt;
    xlor_r <= xlo_re_i;
    xloi_r <= xlo_im_i;
    negr_r <= neg_re_i;
    negi_r <= neg_im_i;
    ovfr_r <= ovf_re_i;
    ovfi_r <= ovf_im_i;
  end

  assign ctl_o      = ctl_r;
  assign den_o      = den_r;
  assign pass_re_o  = pre_r;
  assign pass_im_o  = pim_r;
  assign pass_sat_o = psat_r;
  assign rem_re_o   = remr_r;
  assign rem_im_o   = remi_r;
  assign q_re_o     = qr_r;
  assign q_im_o     = qi_r;
  assign xlo_re_o   = xlor_r;
  assign xlo_im_o   = xloi_r;
  assign neg_re_o   = negr_r;
  assign neg_im_o   = negi_r;
  assign ovf_re_o   = ovfr_r;
  assign ovf_im_o   = ovfi_r;

endmodule

// ===== rtl/core/complex_arith_unit_top.sv =====
// Complex arithmetic unit: signed fixed-point complex add, subtract, multiply
// and divide. Depends on cau_pkg, cau_front and cau_div_step.
//
// Usage:
//   An item (in_cmd, in_a_re, in_a_im, in_b_re, in_b_im) is taken at a rising
//   edge where start is high and busy is low. busy is always low: the unit is
//   a fixed-length pipeline and takes a new item every cycle.
//   in_cmd: add, subtract, multiply, divide. Operands and results are signed
//   with FRAC_BITS fraction bits.
//   Each item gives one result on out_res_re, out_res_im, out_saturated and
//   out_divide_by_zero, shown for one cycle with out_valid high, in the order
//   the items came in.
//   Every command takes the same path from accept to strobe: four front stages
//   (multipliers, product sums, clip or sign/magnitude, quotient overflow
//   check), one divider stage per quotient bit (DATA_WIDTH + 1 of them), and
//   the output register.
//   Throughput: one item per cycle.
//   Reset clears every valid bit; items in flight are dropped and no strobe
//   follows until a new item is taken.
//   The receiver has no way to stall; results must be taken as they appear.
module complex_arith_unit_top import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_cmd,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic                         out_saturated,
  output logic                         out_divide_by_zero
);

  localparam int DW = DATA_WIDTH;
  localparam int RW = 2 * DW;
  localparam int QW = DW + 1;

  localparam logic [DW-1:0] RMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] RMIN = {1'b1, {(DW-1){1'b0}}};

  // signed clip of a truncated quotient magnitude; returns {sat, value}
  function automatic logic [DW:0] fin_f(input logic [QW-1:0] q, input logic neg,
                                        input logic ovf);
    logic [DW:0] res;
    logic [DW-1:0] nq;
    nq = -q[DW-1:0];
    if (!neg) begin
      if (ovf || (q[QW-1:DW-1] != '0)) begin
        res = {1'b1, RMAX};
      end else begin
        res = {1'b0, q[DW-1:0]};
      end
    end else begin
      if (ovf || q[DW] || (q[DW-1] && (q[DW-2:0] != '0))) begin
        res = {1'b1, RMIN};
      end else begin
        res = {1'b0, nq};
      end
    end
    return res;
  endfunction

  assign busy = 1'b0;

  // pipeline taps: index 0 is the front end output, index k+1 follows step k
  ctl_t          ctl_s   [0:QW];
  logic [RW-1:0] den_s   [0:QW];
  logic [DW-1:0] pre_s   [0:QW];
  logic [DW-1:0] pim_s   [0:QW];
  logic          psat_s  [0:QW];
  logic [RW-1:0] remr_s  [0:QW];
  logic [RW-1:0] remi_s  [0:QW];
  logic [QW-1:0] qr_s    [0:QW];
  logic [QW-1:0] qi_s    [0:QW];
  logic [QW-1:0] xlor_s  [0:QW];
  logic [QW-1:0] xloi_s  [0:QW];
  logic          negr_s  [0:QW];
  logic          negi_s  [0:QW];
  logic          ovfr_s  [0:QW];
  logic          ovfi_s  [0:QW];

  cau_front #(
    .DW (DW),
    .FB (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (start),
    .in_cmd     (in_cmd),
    .a_re       (in_a_re),
    .a_im       (in_a_im),
    .b_re       (in_b_re),
    .b_im       (in_b_im),
    .ctl_o      (ctl_s[0]),
    .den_o      (den_s[0]),
    .pass_re_o  (pre_s[0]),
    .pass_im_o  (pim_s[0]),
    .pass_sat_o (psat_s[0]),
    .rem_re_o   (remr_s[0]),
    .rem_im_o   (remi_s[0]),
    .xlo_re_o   (xlor_s[0]),
    .xlo_im_o   (xloi_s[0]),
    .neg_re_o   (negr_s[0]),
    .neg_im_o   (negi_s[0]),
    .ovf_re_o   (ovfr_s[0]),
    .ovf_im_o   (ovfi_s[0])
  );

  assign qr_s[0] = '0;
  assign qi_s[0] = '0;

  // quotient bits from the top down, one per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    cau_div_step #(
      .DW  (DW),
      .BIT (DW - k)
    ) u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl_s[k]),
      .den_i      (den_s[k]),
      .pass_re_i  (pre_s[k]),
      .pass_im_i  (pim_s[k]),
      .pass_sat_i (psat_s[k]),
      .rem_re_i   (remr_s[k]),
      .rem_im_i   (remi_s[k]),
      .q_re_i     (qr_s[k]),
      .q_im_i     (qi_s[k]),
      .xlo_re_i   (xlor_s[k]),
      .xlo_im_i   (xloi_s[k]),
      .neg_re_i   (negr_s[k]),
      .neg_im_i   (negi_s[k]),
      .ovf_re_i   (ovfr_s[k]),
      .ovf_im_i   (ovfi_s[k]),
      .ctl_o      (ctl_s[k+1]),
      .den_o      (den_s[k+1]),
      .pass_re_o  (pre_s[k+1]),
      .pass_im_o  (pim_s[k+1]),
      .pass_sat_o (psat_s[k+1]),
      .rem_re_o   (remr_s[k+1]),
      .rem_im_o   (remi_s[k+1]),
      .q_re_o     (qr_s[k+1]),
      .q_im_o     (qi_s[k+1]),
      .xlo_re_o   (xlor_s[k+1]),
      .xlo_im_o   (xloi_s[k+1]),
      .neg_re_o   (negr_s[k+1]),
      .neg_im_o   (negi_s[k+1]),
      .ovf_re_o   (ovfr_s[k+1]),
      .ovf_im_o   (ovfi_s[k+1])
    );
  end

  // output stage
  logic          vld_r;
  logic [DW-1:0] re_r, im_r, re_nxt, im_nxt;
  logic          sat_r, dz_r, sat_nxt, dz_nxt;
  logic [DW:0]   fr, fi;

  always_comb begin
    fr = fin_f(qr_s[QW], negr_s[QW], ovfr_s[QW]);
    fi = fin_f(qi_s[QW], negi_s[QW], ovfi_s[QW]);
    if (ctl_s[QW].cmd != CMD_DIV) begin
      re_nxt  = pre_s[QW];
      im_nxt  = pim_s[QW];
      sat_nxt = psat_s[QW];
      dz_nxt  = 1'b0;
    end else if (ctl_s[QW].dz) begin
      re_nxt  = '0;
      im_nxt  = '0;
      sat_nxt = 1'b0;
      dz_nxt  = 1'b1;
    end else begin
      re_nxt  = fr[DW-1:0];
      im_nxt  = fi[DW-1:0];
      sat_nxt = fr[DW] | fi[DW];
      dz_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl_s[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    sat_r <= sat_nxt;
    dz_r  <= dz_nxt;
  end

  assign out_valid          = vld_r;
  assign out_res_re         = re_r;
  assign out_res_im         = im_r;
  assign out_saturated      = sat_r;
  assign out_divide_by_zero = dz_r;

endmodule

// ===== tb/tb_complex_arith_unit_top.sv =====
// testbench for complex_arith_unit_top: directed and random complex add, subtract,
// multiply and divide items checked against an in-bench fixed-point predictor
// depends on cau_pkg and complex_arith_unit_top
`timescale 1ns / 1ps

module tb_complex_arith_unit_top;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam longint FIELD_MAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint FIELD_MIN = -(longint'(1) <<< (DW - 1));
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = DW + 16;

  localparam logic signed [DW-1:0] Q_MAX = 16'sh7fff;
  localparam logic signed [DW-1:0] Q_MIN = 16'sh8000;
  localparam logic signed [DW-1:0] Q_ONE = 16'sh0100;

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 sat;
    logic                 dz;
  } cplx_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_cmd = CMD_ADD;
  logic signed [DW-1:0] in_a_re = '0;
  logic signed [DW-1:0] in_a_im = '0;
  logic signed [DW-1:0] in_b_re = '0;
  logic signed [DW-1:0] in_b_im = '0;
  logic                 out_valid;
  logic signed [DW-1:0] out_res_re;
  logic signed [DW-1:0] out_res_im;
  logic                 out_saturated;
  logic                 out_divide_by_zero;

  cplx_result_t pending_results[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  bit           idle_en = 1'b1;

  complex_arith_unit_top #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_a_re           (in_a_re),
    .in_a_im           (in_a_im),
    .in_b_re           (in_b_re),
    .in_b_im           (in_b_im),
    .out_valid         (out_valid),
    .out_res_re        (out_res_re),
    .out_res_im        (out_res_im),
    .out_saturated     (out_saturated),
    .out_divide_by_zero(out_divide_by_zero)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit out_of_range(longint v);
    return (v > FIELD_MAX) || (v < FIELD_MIN);
  endfunction

  function automatic logic signed [DW-1:0] clip_part(longint v);
    if (v > FIELD_MAX) return FIELD_MAX[DW-1:0];
    if (v < FIELD_MIN) return FIELD_MIN[DW-1:0];
    return v[DW-1:0];
  endfunction

  // exact products and sums in 64 bits, then floor shift or truncating divide
  function automatic cplx_result_t complex_result_of(cmd_t op,
      logic signed [DW-1:0] a_re, logic signed [DW-1:0] a_im,
      logic signed [DW-1:0] b_re, logic signed [DW-1:0] b_im);
    cplx_result_t r;
    longint ar, ai, br, bi, part_re, part_im, den;
    ar = a_re;
    ai = a_im;
    br = b_re;
    bi = b_im;
    r.dz = 1'b0;
    case (op)
      CMD_ADD: begin
        part_re = ar + br;
        part_im = ai + bi;
      end
      CMD_SUB: begin
        part_re = ar - br;
        part_im = ai - bi;
      end
      CMD_MUL: begin
        part_re = (ar * br - ai * bi) >>> FB;
        part_im = (ar * bi + ai * br) >>> FB;
      end
      default: begin
        if (br == 0 && bi == 0) begin
          part_re = 0;
          part_im = 0;
          r.dz = 1'b1;
        end else begin
          den = br * br + bi * bi;
          // longint division truncates toward zero
          part_re = ((ar * br + ai * bi) * (longint'(1) <<< FB)) / den;
          part_im = ((ai * br - ar * bi) * (longint'(1) <<< FB)) / den;
        end
      end
    endcase
    r.re  = clip_part(part_re);
    r.im  = clip_part(part_im);
    r.sat = out_of_range(part_re) || out_of_range(part_im);
    return r;
  endfunction

  // pop on strobe first, then record the item taken at this edge
  always @(posedge clk) begin : result_check
    cplx_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: re %0d im %0d", out_res_re, out_res_im);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_res_re !== want.re) begin
            $error("res_re: expected %0d, got %0d", want.re, out_res_re);
            fail_count++;
          end
          if (out_res_im !== want.im) begin
            $error("res_im: expected %0d, got %0d", want.im, out_res_im);
            fail_count++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, out_saturated);
            fail_count++;
          end
          if (out_divide_by_zero !== want.dz) begin
            $error("divide_by_zero: expected %0b, got %0b", want.dz, out_divide_by_zero);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(complex_result_of(cmd_t'(in_cmd), in_a_re, in_a_im,
                                                    in_b_re, in_b_im));
      end
    end
  end

  task automatic send_item(cmd_t op, logic signed [DW-1:0] a_re, logic signed [DW-1:0] a_im,
                           logic signed [DW-1:0] b_re, logic signed [DW-1:0] b_im);
    while (idle_en && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_cmd  <= op;
    in_a_re <= a_re;
    in_a_im <= a_im;
    in_b_re <= b_re;
    in_b_im <= b_im;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] random_operand();
    logic signed [DW-1:0] corner[7] = '{Q_MIN, Q_MAX, 16'sh8001, 16'sh7ffe, 0, 1, -1};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DW'($urandom);
      4, 5, 6, 7: return DW'($urandom_range(0, 2047)) - 16'sd1024;
      8:          return corner[$urandom_range(0, 6)];
      default:    return Q_ONE;
    endcase
  endfunction

  task automatic test_add_sub();
    send_item(CMD_ADD, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_item(CMD_ADD, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_item(CMD_ADD, 1, -1, -1, 1);
    send_item(CMD_ADD, Q_MAX, 0, 16'sh0001, 0);
    send_item(CMD_SUB, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
    send_item(CMD_SUB, 0, Q_MAX, Q_MIN, -1);
    send_item(CMD_SUB, 16'sh1234, -16'sh0765, 16'sh0234, 16'sh0100);
  endtask

  task automatic test_multiply();
    send_item(CMD_MUL, Q_MIN, 0, Q_MIN, 0);
    send_item(CMD_MUL, Q_ONE, 0, 16'sh1357, -16'sh2468);
    // negative product below one lsb floors to -1
    send_item(CMD_MUL, -1, 0, 1, 0);
    send_item(CMD_MUL, Q_MAX, Q_MAX, Q_MAX, -Q_MAX);
    send_item(CMD_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_item(CMD_MUL, 16'sh0180, -16'sh0040, -16'sh0200, 16'sh0300);
  endtask

  task automatic test_divide();
    send_item(CMD_DIV, 16'sh0500, -16'sh0300, 0, 0);
    send_item(CMD_DIV, Q_MIN, Q_MAX, 0, 0);
    send_item(CMD_DIV, Q_ONE, 0, Q_ONE, 0);
    send_item(CMD_DIV, Q_MIN, Q_MIN, 1, 0);
    // quotient magnitude below one lsb truncates to zero
    send_item(CMD_DIV, -1, 0, 16'sh0200, 0);
    send_item(CMD_DIV, 16'sh0300, 16'sh0100, 0, Q_MIN);
    send_item(CMD_DIV, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    send_item(CMD_DIV, 16'sh0100, 16'sh0200, 16'sh0300, -16'sh0400);
  endtask

  task automatic test_pause_drain();
    for (int i = 0; i < 40; i++) begin
      send_item(cmd_t'($urandom_range(0, 3)), random_operand(), random_operand(),
                random_operand(), random_operand());
    end
    wait_for_drain();
    for (int i = 0; i < 10; i++) begin
      send_item(cmd_t'($urandom_range(0, 3)), random_operand(), random_operand(),
                random_operand(), random_operand());
    end
  endtask

  task automatic test_random_mix(int n_items);
    cmd_t                 op;
    logic signed [DW-1:0] br, bi;
    for (int i = 0; i < n_items; i++) begin
      // long stretch with the sender never idling
      idle_en = !(i >= n_items / 3 && i < n_items / 3 + 400);
      op = cmd_t'($urandom_range(0, 3));
      br = random_operand();
      bi = random_operand();
      if (op == CMD_DIV) begin
        case ($urandom_range(0, 11))
          0:       begin br = 0; bi = 0; end
          1:       br = 0;
          2:       bi = 0;
          default: ;
        endcase
      end
      send_item(op, random_operand(), random_operand(), br, bi);
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_add_sub();
    test_multiply();
    test_divide();
    test_pause_drain();
    test_random_mix(1750);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div_step.sv
rtl/core/complex_arith_unit_top.sv
tb/tb_complex_arith_unit_top.sv
